FILE: hw/rtl/c32cc_pkg.sv
// ----------------------------------------------------------------------------
// c32cc_pkg: shared definitions for the CRC32-C combine block
// Constants, controller states, command and status structs, GF(2) helpers.
// ----------------------------------------------------------------------------
package c32cc_pkg;

  localparam int CRC_W        = 32;
  localparam int IN_LEN_W     = 64;
  localparam int LENGTH_WIDTH = 64;
  localparam int ROW_W        = $clog2(CRC_W);
  localparam int PREP_W       = 2;

  localparam logic [CRC_W-1:0]  CRC_POLY     = 32'h82F63B78;
  localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(CRC_W - 1);
  localparam logic [PREP_W-1:0] PREP_SQUARES = PREP_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_STEP,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic             load;
    logic             square;
    logic [ROW_W-1:0] row;
    logic             last_row;
    logic             apply;
    logic             shift;
    logic             emit;
    logic             bypass;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic len_lsb;
    logic len_last;
  } dp_sts_t;

  typedef logic [CRC_W-1:0] crc_mat_t [CRC_W];

  // Column i of the operator that advances the register by one zero bit.
  function automatic logic [CRC_W-1:0] one_bit_col(input int unsigned idx);
    logic [CRC_W-1:0] col;
    if (idx == 0) begin
      col = CRC_POLY;
    end else begin
      col = {{(CRC_W-1){1'b0}}, 1'b1} << (idx - 1);
    end
    return col;
  endfunction

  // GF(2) matrix times vector: XOR of the columns selected by the vector bits.
  function automatic logic [CRC_W-1:0] gf2_apply(input crc_mat_t m,
                                                 input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < CRC_W; i++) begin
      acc = acc ^ (m[i] & {CRC_W{v[i]}});
    end
    return acc;
  endfunction

endpackage

FILE: hw/rtl/c32cc_dp.sv
// ----------------------------------------------------------------------------
// c32cc_dp: datapath of the CRC32-C combine block
// Two ping-pong operator banks, one shared matrix-vector unit, the running
// CRC, the length shifter and the result register.
// ----------------------------------------------------------------------------
module c32cc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  c32cc_pkg::dp_cmd_t            cmd,
  output c32cc_pkg::dp_sts_t            sts,
  input  logic [c32cc_pkg::CRC_W-1:0]   in_first_crc,
  input  logic [c32cc_pkg::CRC_W-1:0]   in_second_crc,
  input  logic [c32cc_pkg::IN_LEN_W-1:0] in_second_length,
  output logic [c32cc_pkg::CRC_W-1:0]   out_joined_crc
);
  import c32cc_pkg::*;

  logic [CRC_W-1:0]        bank0_r [CRC_W];
  logic [CRC_W-1:0]        bank1_r [CRC_W];
  logic                    sel_r;
  logic [CRC_W-1:0]        crc_r;
  logic [CRC_W-1:0]        second_r;
  logic [LENGTH_WIDTH-1:0] len_r;
  logic [CRC_W-1:0]        out_crc_r;

  crc_mat_t         src;
  logic [CRC_W-1:0] vec;
  logic [CRC_W-1:0] prod;

  always_comb begin
    for (int i = 0; i < CRC_W; i++) begin
      src[i] = sel_r ? bank1_r[i] : bank0_r[i];
    end
    vec  = cmd.square ? src[cmd.row] : crc_r;
    prod = gf2_apply(src, vec);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (cmd.load) begin
      sel_r <= 1'b0;
    end else if (cmd.square && cmd.last_row) begin
      sel_r <= ~sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < CRC_W; i++) begin
        bank0_r[i] <= one_bit_col(i);
      end
      crc_r    <= in_first_crc;
      second_r <= in_second_crc;
      len_r    <= in_second_length[LENGTH_WIDTH-1:0];
    end else begin
      if (cmd.square) begin
        if (sel_r) begin
          bank0_r[cmd.row] <= prod;
        end else begin
          bank1_r[cmd.row] <= prod;
        end
      end
      if (cmd.apply) begin
        crc_r <= prod;
      end
      if (cmd.shift) begin
        len_r <= len_r >> 1;
      end
    end
    if (cmd.emit) begin
      out_crc_r <= cmd.bypass ? crc_r : (crc_r ^ second_r);
    end
  end

  assign sts.len_zero = (len_r == '0);
  assign sts.len_lsb  = len_r[0];
  assign sts.len_last = ((len_r >> 1) == '0);

  assign out_joined_crc = out_crc_r;

endmodule

FILE: hw/rtl/c32cc_ctl.sv
// ----------------------------------------------------------------------------
// c32cc_ctl: controller of the CRC32-C combine block
// Sequences operator squarings row by row, length-bit steps and the result.
// ----------------------------------------------------------------------------
module c32cc_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output c32cc_pkg::dp_cmd_t cmd,
  input  c32cc_pkg::dp_sts_t sts
);
  import c32cc_pkg::*;

  ctl_state_t        state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PREP_W-1:0] prep_r, prep_nxt;
  logic              bypass_r, bypass_nxt;
  logic              valid_r, valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      row_r    <= '0;
      prep_r   <= '0;
      bypass_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      prep_r   <= prep_nxt;
      bypass_r <= bypass_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    prep_nxt   = prep_r;
    bypass_nxt = bypass_r;
    valid_nxt  = 1'b0;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        row_nxt  = '0;
        prep_nxt = '0;
        if (sts.len_zero) begin
          bypass_nxt = 1'b1;
          state_nxt  = ST_FINISH;
        end else begin
          bypass_nxt = 1'b0;
          state_nxt  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square   = 1'b1;
        cmd.row      = row_r;
        cmd.last_row = (row_r == ROW_LAST);
        row_nxt      = row_r + ROW_W'(1);
        if (row_r == ROW_LAST) begin
          if (prep_r == PREP_SQUARES) begin
            state_nxt = ST_STEP;
          end else begin
            prep_nxt = prep_r + PREP_W'(1);
          end
        end
      end
      ST_STEP: begin
        cmd.apply = sts.len_lsb;
        cmd.shift = 1'b1;
        state_nxt = sts.len_last ? ST_FINISH : ST_SQUARE;
      end
      ST_FINISH: begin
        cmd.emit   = 1'b1;
        cmd.bypass = bypass_r;
        valid_nxt  = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = valid_r;

endmodule

FILE: hw/rtl/crc32c_combine.sv
// ----------------------------------------------------------------------------
// crc32c_combine: join two CRC32-C values
// An item is taken when start is high and busy is low. For a zero length the
// result strobe out_valid rises from a register after the CHECK and FINISH
// states. Otherwise, with k the position of the highest set length bit plus
// one, the operator is squared k+2 times at one matrix row per cycle on the
// single shared matrix-vector unit, with one STEP state per length bit, and
// FINISH then raises the strobe. The result stands on out_joined_crc for
// the one cycle out_valid is high; the receiver cannot hold it off. A new
// beat may be started in that same cycle.
// ----------------------------------------------------------------------------
module crc32c_combine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [c32cc_pkg::CRC_W-1:0]    in_first_crc,
  input  logic [c32cc_pkg::CRC_W-1:0]    in_second_crc,
  input  logic [c32cc_pkg::IN_LEN_W-1:0] in_second_length,
  output logic                           out_valid,
  output logic [c32cc_pkg::CRC_W-1:0]    out_joined_crc
);
  import c32cc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  c32cc_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  c32cc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_first_crc     (in_first_crc),
    .in_second_crc    (in_second_crc),
    .in_second_length (in_second_length),
    .out_joined_crc   (out_joined_crc)
  );

endmodule

FILE: hw/rtl/c32cc_chk.sv
// ----------------------------------------------------------------------------
// c32cc_chk: port-level checks for the CRC32-C combine block
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module c32cc_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [c32cc_pkg::CRC_W-1:0]    in_first_crc,
  input logic [c32cc_pkg::IN_LEN_W-1:0] in_second_length,
  input logic                           out_valid,
  input logic [c32cc_pkg::CRC_W-1:0]    out_joined_crc
);
  import c32cc_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted beat");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while the block is busy");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_second_length[LENGTH_WIDTH-1:0] == '0) |->
      ##3 (out_valid && out_joined_crc == $past(in_first_crc, 3)))
    else $error("zero length did not return the first CRC on time");

endmodule

bind crc32c_combine c32cc_chk u_c32cc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_first_crc     (in_first_crc),
  .in_second_length (in_second_length),
  .out_valid        (out_valid),
  .out_joined_crc   (out_joined_crc)
);
